[rtl/core/cbts_pkg.sv]
package cbts_pkg;

    // Field widths of one item and one result
    localparam int CLK_W    = 27;
    localparam int CODE_W   = 3;
    localparam int PRESC_W  = 10;
    localparam int PH1_W    = 5;
    localparam int PH2_W    = 2;
    localparam int JW_W     = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam int TOL_W      = 17;
    localparam int PCT_W      = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_POINT = 1'b1;

    localparam logic [TOL_W-1:0] TOL_RESET = 17'd10000;
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd85;

    // Bitrate targets and derived bounds fit in 21 bits (target + tolerance)
    localparam int KW = 21;

    // Segment sum counter and phase arithmetic
    localparam int SEG_W   = 5;
    localparam int PROD_W  = 12;
    localparam int RECIP_W = 13;
    localparam int QPROD_W = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
    localparam int                 RECIP_SHIFT = 19;
    localparam logic [SEG_W-1:0]   SEG_FIRST   = 5'd3;
    localparam logic [6:0]         ROUND_LIMIT = 7'd50;

    localparam logic [JW_W-1:0] JW_EXACT  = 2'd1;
    localparam logic [JW_W-1:0] JW_APPROX = 2'd3;
    localparam logic [JW_W-1:0] JW_NONE   = 2'd0;

    typedef enum logic [CODE_W-1:0] {
        SPEED_1M   = 3'd0,
        SPEED_500K = 3'd1,
        SPEED_250K = 3'd2,
        SPEED_125K = 3'd3
    } t_speed;

    typedef enum logic [1:0] {
        ST_EXACT   = 2'd0,
        ST_APPROX  = 2'd1,
        ST_NONE    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef struct packed {
        logic [CLK_W-1:0]  clock_hz;
        logic [CODE_W-1:0] speed_code;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [PRESC_W-1:0] prescaler_code;
        logic [PH1_W-1:0]   phase1_code;
        logic [PH2_W-1:0]   phase2_code;
        logic [JW_W-1:0]    jump_width_code;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic prep;
        logic next_s;
        logic next_p;
        logic ph_mul;
        logic ph_div;
        logic ph_fin;
        logic set_invalid;
        logic set_none;
        logic pass;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic code_valid;
        logic hit;
        logic row_end;
        logic p_last;
    } t_stat;

    function automatic logic [KW-1:0] target_hz(input logic [CODE_W-1:0] code);
        logic [KW-1:0] t;
        unique case (code)
            SPEED_1M:   t = 21'd1000000;
            SPEED_500K: t = 21'd500000;
            SPEED_250K: t = 21'd250000;
            SPEED_125K: t = 21'd125000;
            default:    t = '0;
        endcase
        return t;
    endfunction

    function automatic logic speed_valid(input logic [CODE_W-1:0] code);
        return (code == SPEED_1M) || (code == SPEED_500K) ||
               (code == SPEED_250K) || (code == SPEED_125K);
    endfunction

endpackage

[rtl/core/cbts_ctrl.sv]
module cbts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  cbts_pkg::t_stat i_stat,
    output cbts_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SETUP  = 8'b0000_0010,
        S_PREP   = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_PH_MUL = 8'b0001_0000,
        S_PH_DIV = 8'b0010_0000,
        S_PH_FIN = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        o_cmd   = '0;
        o_cmd.pass = r_pass;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_stat.code_valid) begin
                    o_cmd.setup = 1'b1;
                    n_pass      = 1'b0;
                    n_state     = S_PREP;
                end else begin
                    o_cmd.set_invalid = 1'b1;
                    n_state           = S_DONE;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                priority if (i_stat.hit) begin
                    n_state = S_PH_MUL;
                end else if (i_stat.row_end && i_stat.p_last) begin
                    if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_state = S_PREP;
                    end else begin
                        o_cmd.set_none = 1'b1;
                        n_state        = S_DONE;
                    end
                end else if (i_stat.row_end) begin
                    o_cmd.next_p = 1'b1;
                end else begin
                    o_cmd.next_s = 1'b1;
                end
            end
            S_PH_MUL: begin
                o_cmd.ph_mul = 1'b1;
                n_state      = S_PH_DIV;
            end
            S_PH_DIV: begin
                o_cmd.ph_div = 1'b1;
                n_state      = S_PH_FIN;
            end
            S_PH_FIN: begin
                o_cmd.ph_fin = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

[rtl/core/cbts_datapath.sv]
module cbts_datapath #(
    parameter int PRESCALER_LIMIT = 1024,
    parameter int SEGMENT_LIMIT   = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cbts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cbts_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  cbts_pkg::t_item                     i_item,
    input  cbts_pkg::t_cmd                      i_cmd,
    output cbts_pkg::t_stat                     o_stat,
    output cbts_pkg::t_result                   o_result
);

    localparam int DIV_MAX = PRESCALER_LIMIT * (SEGMENT_LIMIT + 2);
    localparam int DIV_W   = $clog2(DIV_MAX + 1);
    localparam int ACC_A   = cbts_pkg::KW + DIV_W;
    localparam int ACC_W   = (ACC_A > cbts_pkg::CLK_W + 1) ? ACC_A : cbts_pkg::CLK_W + 1;
    localparam int P_W     = $clog2(PRESCALER_LIMIT);
    localparam int NK      = 3;
    localparam int K_T     = 0;   // target
    localparam int K_H     = 1;   // target + tolerance
    localparam int K_L     = 2;   // target - tolerance + 1

    // Configuration registers
    logic [cbts_pkg::TOL_W-1:0] r_tol;
    logic [cbts_pkg::PCT_W-1:0] r_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= cbts_pkg::TOL_RESET;
            r_pct <= cbts_pkg::PCT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cbts_pkg::CFG_TOLERANCE:    r_tol <= i_cfg_data;
                cbts_pkg::CFG_SAMPLE_POINT: r_pct <= i_cfg_data[cbts_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [cbts_pkg::CLK_W-1:0]  r_clk;
    logic [cbts_pkg::CODE_W-1:0] r_code;
    logic [cbts_pkg::KW-1:0]     r_k [NK];
    logic                        r_lo_always;
    logic [ACC_W-1:0]            r_step [NK];
    logic [ACC_W-1:0]            r_six  [NK];
    logic [ACC_W-1:0]            r_row  [NK];
    logic [ACC_W-1:0]            r_acc  [NK];
    logic [P_W-1:0]              r_p;
    logic [cbts_pkg::SEG_W-1:0]  r_s;
    logic [cbts_pkg::PROD_W-1:0] r_prod;
    logic [cbts_pkg::PH1_W-1:0]  r_quot;
    cbts_pkg::t_result           r_result;

    // Bounds for the current speed code
    logic [cbts_pkg::KW-1:0] tgt;
    logic [cbts_pkg::KW-1:0] tol_ext;
    logic                    lo_always;

    assign tgt       = cbts_pkg::target_hz(r_code);
    assign tol_ext   = cbts_pkg::KW'(r_tol);
    assign lo_always = (tol_ext > tgt);

    logic [ACC_W-1:0] six_k [NK];
    logic [ACC_W-1:0] k_ext [NK];

    always_comb begin
        for (int i = 0; i < NK; i++) begin
            k_ext[i] = ACC_W'(r_k[i]);
            six_k[i] = (k_ext[i] << 2) + (k_ext[i] << 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clk  <= i_item.clock_hz;
            r_code <= i_item.speed_code;
        end
        if (i_cmd.setup) begin
            r_k[K_T]    <= tgt;
            r_k[K_H]    <= tgt + tol_ext;
            r_k[K_L]    <= lo_always ? '0 : tgt - tol_ext + cbts_pkg::KW'(1);
            r_lo_always <= lo_always;
        end
        for (int i = 0; i < NK; i++) begin
            if (i_cmd.prep) begin
                r_step[i] <= k_ext[i];
                r_six[i]  <= six_k[i];
                r_row[i]  <= six_k[i];
                r_acc[i]  <= six_k[i];
            end else if (i_cmd.next_p) begin
                r_step[i] <= r_step[i] + k_ext[i];
                r_row[i]  <= r_row[i] + r_six[i];
                r_acc[i]  <= r_row[i] + r_six[i];
            end else if (i_cmd.next_s) begin
                r_acc[i]  <= r_acc[i] + r_step[i];
            end
        end
        if (i_cmd.prep) begin
            r_p <= '0;
            r_s <= cbts_pkg::SEG_FIRST;
        end else if (i_cmd.next_p) begin
            r_p <= r_p + P_W'(1);
            r_s <= cbts_pkg::SEG_FIRST;
        end else if (i_cmd.next_s) begin
            r_s <= r_s + cbts_pkg::SEG_W'(1);
        end
    end

    // Candidate tests, all on clk against K * divider
    logic [ACC_W-1:0] clk_ext;
    logic             below_t;
    logic             hit_exact;
    logic             hit_approx;

    assign clk_ext    = ACC_W'(r_clk);
    assign below_t    = (clk_ext < r_acc[K_T]);
    assign hit_exact  = (clk_ext == r_acc[K_T]);
    assign hit_approx = (clk_ext < r_acc[K_H]) && (r_lo_always || (clk_ext >= r_acc[K_L]));

    assign o_stat.code_valid = cbts_pkg::speed_valid(r_code);
    assign o_stat.hit        = i_cmd.pass ? hit_approx : hit_exact;
    assign o_stat.row_end    = below_t || (r_s == cbts_pkg::SEG_W'(SEGMENT_LIMIT - 1));
    assign o_stat.p_last     = (r_p == P_W'(PRESCALER_LIMIT - 1));

    // Phase split: s * percent / 100 through a reciprocal
    logic [cbts_pkg::QPROD_W-1:0] qprod;
    logic [cbts_pkg::PROD_W-1:0]  quot_x100;
    logic [cbts_pkg::PROD_W-1:0]  rem_full;
    logic [6:0]                   rem;
    logic [cbts_pkg::PH1_W:0]     ph1_raw;
    logic [cbts_pkg::PH1_W:0]     ph1_clamp;
    logic [cbts_pkg::SEG_W-1:0]   ph2_raw;
    logic [cbts_pkg::PH1_W-1:0]   ph1_out;
    logic [cbts_pkg::PH2_W-1:0]   ph2_out;

    assign qprod     = cbts_pkg::QPROD_W'(r_prod) * cbts_pkg::QPROD_W'(cbts_pkg::RECIP_100);
    assign quot_x100 = (cbts_pkg::PROD_W'(r_quot) << 6) + (cbts_pkg::PROD_W'(r_quot) << 5)
                     + (cbts_pkg::PROD_W'(r_quot) << 2);
    assign rem_full  = r_prod - quot_x100;
    assign rem       = rem_full[6:0];
    assign ph1_raw   = {1'b0, r_quot} + ((rem > cbts_pkg::ROUND_LIMIT) ? 6'd1 : 6'd0);
    assign ph1_clamp = (ph1_raw > {1'b0, r_s}) ? {1'b0, r_s} : ph1_raw;
    assign ph2_raw   = r_s - ph1_clamp[cbts_pkg::PH1_W-1:0];
    assign ph1_out   = ph1_clamp[cbts_pkg::PH1_W] ? '1 : ph1_clamp[cbts_pkg::PH1_W-1:0];
    assign ph2_out   = (ph2_raw > cbts_pkg::SEG_W'(3)) ? '1 : ph2_raw[cbts_pkg::PH2_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.ph_mul) begin
            r_prod <= cbts_pkg::PROD_W'(r_s) * cbts_pkg::PROD_W'(r_pct);
        end
        if (i_cmd.ph_div) begin
            r_quot <= qprod[cbts_pkg::RECIP_SHIFT +: cbts_pkg::PH1_W];
        end
        priority if (i_cmd.ph_fin) begin
            r_result.status          <= i_cmd.pass ? cbts_pkg::ST_APPROX : cbts_pkg::ST_EXACT;
            r_result.prescaler_code  <= cbts_pkg::PRESC_W'(r_p);
            r_result.phase1_code     <= ph1_out;
            r_result.phase2_code     <= ph2_out;
            r_result.jump_width_code <= i_cmd.pass ? cbts_pkg::JW_APPROX : cbts_pkg::JW_EXACT;
        end else if (i_cmd.set_invalid) begin
            r_result <= '{status: cbts_pkg::ST_INVALID, default: '0};
        end else if (i_cmd.set_none) begin
            r_result <= '{status: cbts_pkg::ST_NONE, default: '0};
        end
    end

    assign o_result = r_result;

endmodule

[rtl/core/can_bit_timing_search_unit.sv]
// CAN bit timing search. Pulse start with busy low to hand in one item (clock
// frequency and speed code); busy stays high until the result has been shown.
// The result appears on o_result for exactly one cycle with o_result_strobe
// high; it cannot be stalled, so capture it on that cycle. After the accepting
// edge, busy stays high through SETUP and the result on an invalid speed code.
// Otherwise it stays high through the set-up states SETUP and PREP, the scan
// of divider candidates, a further PREP if the exact pass fails, and then the
// phase split (PH_MUL, PH_DIV, PH_FIN) and result, or only the result when no
// divider exists. The next item is taken on the first cycle with busy low. The
// candidate scan walks one (prescaler, segment) pair per cycle; each prescaler
// row stops as soon as the bitrate drops below target, so the cost is set by
// where the first match lies. Configuration writes land at once and must be
// made while busy is low.
module can_bit_timing_search_unit #(
    parameter int PRESCALER_LIMIT = 1024,
    parameter int SEGMENT_LIMIT   = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [cbts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cbts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // item command
    input  logic                            start,
    output logic                            busy,
    input  cbts_pkg::t_item                 i_item,
    // result
    output logic                            o_result_strobe,
    output cbts_pkg::t_result               o_result
);

    cbts_pkg::t_cmd  cmd;
    cbts_pkg::t_stat stat;

    // Sequence set-up, candidate scan, phase split and result strobe
    cbts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_result_strobe)
    );

    // Hold the item, step the divider accumulators, build the result
    cbts_datapath #(
        .PRESCALER_LIMIT (PRESCALER_LIMIT),
        .SEGMENT_LIMIT   (SEGMENT_LIMIT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_result)
    );

endmodule
